FILE: rtl/bmpu_pkg.sv
// ----------------------------------------------------------------------------
// bmpu_pkg
// Types and constants shared by the monochrome BMP pixel unpacker.
// ----------------------------------------------------------------------------
package bmpu_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PIXEL     = 3'd0,
    KIND_ACCEPTED  = 3'd1,
    KIND_NOT_BMP   = 3'd2,
    KIND_BAD_DEPTH = 3'd3,
    KIND_BAD_SIZE  = 3'd4
  } kind_e;

  localparam int unsigned HDR_BYTES = 54;
  localparam logic [5:0]  POS_SIG0  = 6'd0;
  localparam logic [5:0]  POS_SIG1  = 6'd1;
  localparam logic [5:0]  POS_OFS   = 6'd10;
  localparam logic [5:0]  POS_WID   = 6'd18;
  localparam logic [5:0]  POS_HGT   = 6'd22;
  localparam logic [5:0]  POS_BPP   = 6'd28;
  localparam logic [5:0]  POS_LAST  = 6'(HDR_BYTES - 1);
  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;
  localparam logic [15:0] BPP_MONO  = 16'd1;

  // Output stream data: pixel, column, row, width, height, image done.
  localparam int unsigned OUT_DATA_W = 56;

endpackage

FILE: rtl/bmp_mono_pixel_unpacker.sv
// ----------------------------------------------------------------------------
// bmp_mono_pixel_unpacker
// Streaming decoder for 1-bit-per-pixel BMP files, one file byte per request.
// ----------------------------------------------------------------------------
// The block takes a BMP file one byte per request, parses the 54-byte header,
// sends one status result on header byte 53, skips to the pixel data and then
// sends one result per pixel, MSB first, with row 0 the last stored row. A byte
// that yields no result (header, skip, row padding, after the image) does not
// occupy the unpack stage; a pixel byte holds the unpack stage until each
// pixel it yields has moved on to the output register. The unpack stage
// holds one byte while the output register holds the result in flight, so the
// next byte is taken in the cycle the last pixel of the current one moves on.
// Setting tuser on a byte restarts the parser with that byte as byte 0.
module bmp_mono_pixel_unpacker
  import bmpu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tuser,   // [0] file_start
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] pixel_value, [12:1] column, [24:13] row, [37:25] image_width,
  // [50:38] image_height, [51] image_done, [55:52] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]            m_axis_tuser,   // [2:0] kind
  output logic                  m_axis_tlast    // last_of_run
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned BW = $clog2((MAX_WIDTH + 31) / 32 * 4);
  localparam int unsigned CW = (BW + 3 > WW) ? BW + 3 : WW;

  // Parser state
  phase_e         phase_q, phase_d;
  logic [31:0]    pos_q, pos_d;
  logic [7:0]     sig_q, sig_d;
  logic [31:0]    ofs_q, ofs_d;
  logic [31:0]    wid_q, wid_d;
  logic [31:0]    hgt_q, hgt_d;
  logic [15:0]    bpp_q, bpp_d;
  logic [WH-1:0]  srow_q, srow_d;
  logic [BW-1:0]  bir_q, bir_d;
  logic [BW-1:0]  lastb_q, lastb_d;

  // Current state, seen as reset when the byte starts a new file
  phase_e         c_phase;
  logic [31:0]    c_pos, c_ofs, c_wid, c_hgt;
  logic [7:0]     c_sig;
  logic [15:0]    c_bpp;
  logic [WH-1:0]  c_srow;
  logic [BW-1:0]  c_bir;

  logic           s_fire;
  logic [7:0]     din;
  logic [5:0]     p6;
  logic [1:0]     lane;

  always_comb begin
    c_phase = s_axis_tuser ? PH_HEADER : phase_q;
    c_pos   = s_axis_tuser ? '0 : pos_q;
    c_ofs   = s_axis_tuser ? '0 : ofs_q;
    c_wid   = s_axis_tuser ? '0 : wid_q;
    c_hgt   = s_axis_tuser ? '0 : hgt_q;
    c_sig   = s_axis_tuser ? '0 : sig_q;
    c_bpp   = s_axis_tuser ? '0 : bpp_q;
    c_srow  = s_axis_tuser ? '0 : srow_q;
    c_bir   = s_axis_tuser ? '0 : bir_q;
  end

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign din    = s_axis_tdata;
  // In the header phase the position never passes the last header byte.
  assign p6     = c_pos[5:0];

  // Header check on the last header byte
  logic          wid_ok, hgt_ok, is_last_hdr, empty_img;
  logic [WW-1:0] w_ok_val;
  logic [WH-1:0] h_ok_val;
  kind_e         hdr_kind;
  logic [WW+1:0] lb_full;

  assign wid_ok      = !c_wid[31] && (c_wid <= 32'(MAX_WIDTH));
  assign hgt_ok      = !c_hgt[31] && (c_hgt <= 32'(MAX_HEIGHT));
  assign w_ok_val    = wid_ok ? WW'(c_wid) : '0;
  assign h_ok_val    = hgt_ok ? WH'(c_hgt) : '0;
  assign is_last_hdr = (c_phase == PH_HEADER) && (p6 == POS_LAST);
  assign empty_img   = (w_ok_val == '0) || (h_ok_val == '0);
  // Bytes per stored row are the width rounded up to 32 bits.
  assign lb_full     = (((WW + 2)'(w_ok_val) + (WW + 2)'(31)) >> 5) << 2;

  always_comb begin
    priority if (c_sig != SIG_B) begin
      hdr_kind = KIND_NOT_BMP;
    end else if (c_bpp != BPP_MONO) begin
      hdr_kind = KIND_BAD_DEPTH;
    end else if (!wid_ok || !hgt_ok || c_ofs < 32'(HDR_BYTES)) begin
      hdr_kind = KIND_BAD_SIZE;
    end else begin
      hdr_kind = KIND_ACCEPTED;
    end
  end

  // Pixel byte decode
  logic          pix_byte;
  logic [CW-1:0] base_col, wid_c, remain;
  logic [3:0]    pix_cnt;
  logic          last_row, row_end;
  logic [WH-1:0] row_full;

  assign pix_byte = (c_phase == PH_PIXELS) ||
                    ((c_phase == PH_SKIP) && !(c_pos < c_ofs));
  assign base_col = CW'({c_bir, 3'b000});
  assign wid_c    = CW'(c_wid[WW-1:0]);
  assign remain   = wid_c - base_col;
  assign pix_cnt  = (base_col >= wid_c) ? 4'd0 :
                    (remain >= CW'(8)) ? 4'd8 : 4'(remain);
  assign last_row = (c_srow == WH'(c_hgt[WH-1:0]) - WH'(1));
  assign row_full = WH'(c_hgt[WH-1:0]) - WH'(1) - c_srow;
  assign row_end  = (c_bir == lastb_q);

  // Next state of the parser
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    sig_d   = sig_q;
    ofs_d   = ofs_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    bpp_d   = bpp_q;
    srow_d  = srow_q;
    bir_d   = bir_q;
    lastb_d = lastb_q;
    lane    = '0;
    if (s_fire) begin
      phase_d = c_phase;
      pos_d   = c_pos;
      sig_d   = c_sig;
      ofs_d   = c_ofs;
      wid_d   = c_wid;
      hgt_d   = c_hgt;
      bpp_d   = c_bpp;
      srow_d  = c_srow;
      bir_d   = c_bir;
      unique case (c_phase)
        PH_HEADER: begin
          if (p6 == POS_SIG0) begin
            sig_d = din;
          end else if (p6 == POS_SIG1) begin
            if (din != SIG_M) sig_d = '0;
          end else if (p6 >= POS_OFS && p6 < POS_OFS + 6'd4) begin
            lane = 2'(p6 - POS_OFS);
            ofs_d[8*lane +: 8] = din;
          end else if (p6 >= POS_WID && p6 < POS_WID + 6'd4) begin
            lane = 2'(p6 - POS_WID);
            wid_d[8*lane +: 8] = din;
          end else if (p6 >= POS_HGT && p6 < POS_HGT + 6'd4) begin
            lane = 2'(p6 - POS_HGT);
            hgt_d[8*lane +: 8] = din;
          end else if (p6 >= POS_BPP && p6 < POS_BPP + 6'd2) begin
            lane = 2'(p6 - POS_BPP);
            bpp_d[8*lane[0] +: 8] = din;
          end
          pos_d = c_pos + 32'd1;
          if (is_last_hdr) begin
            lastb_d = BW'(lb_full - (WW + 2)'(1));
            if (hdr_kind != KIND_ACCEPTED || empty_img) begin
              phase_d = PH_DONE;
            end else if (c_ofs > 32'(HDR_BYTES)) begin
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_PIXELS;
            end
          end
        end
        PH_SKIP, PH_PIXELS: begin
          if (!pix_byte) begin
            pos_d = c_pos + 32'd1;
          end else begin
            phase_d = PH_PIXELS;
            if (row_end) begin
              bir_d  = '0;
              srow_d = c_srow + WH'(1);
              if (last_row) phase_d = PH_DONE;
            end else begin
              bir_d = c_bir + BW'(1);
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Unpack stage: one accepted byte and the results it still owes
  logic          job_vld_q, job_vld_d;
  kind_e         job_kind_q;
  logic [7:0]    job_byte_q;
  logic [CW-1:0] job_base_q;
  logic [11:0]   job_row_q;
  logic [3:0]    job_cnt_q;
  logic [2:0]    job_idx_q, job_idx_d;
  logic [WW-1:0] job_w_q;
  logic [WH-1:0] job_h_q;
  logic          job_lrow_q;
  logic          job_done_q;

  logic          new_job;
  logic          out_load, job_last;
  logic [CW-1:0] j_col;
  logic          j_pix, j_done;

  assign new_job  = s_fire && (is_last_hdr || (pix_byte && pix_cnt != 4'd0));
  assign j_col    = job_base_q + CW'(job_idx_q);
  assign job_last = (4'(job_idx_q) + 4'd1 == job_cnt_q);
  assign out_load = job_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !job_vld_q || (out_load && job_last);

  // Result selection for the unpack stage
  always_comb begin
    if (job_kind_q == KIND_PIXEL) begin
      j_pix  = job_byte_q[3'd7 - job_idx_q];
      j_done = job_lrow_q && (j_col + CW'(1) == CW'(job_w_q));
    end else begin
      j_pix  = 1'b0;
      j_done = job_done_q;
    end
  end

  always_comb begin
    job_vld_d = job_vld_q;
    job_idx_d = job_idx_q;
    if (out_load) begin
      if (job_last) begin
        job_vld_d = 1'b0;
      end else begin
        job_idx_d = job_idx_q + 3'd1;
      end
    end
    if (new_job) begin
      job_vld_d = 1'b1;
      job_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      sig_q     <= '0;
      ofs_q     <= '0;
      wid_q     <= '0;
      hgt_q     <= '0;
      bpp_q     <= '0;
      srow_q    <= '0;
      bir_q     <= '0;
      lastb_q   <= '0;
      job_vld_q <= 1'b0;
      job_idx_q <= '0;
    end else begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      sig_q     <= sig_d;
      ofs_q     <= ofs_d;
      wid_q     <= wid_d;
      hgt_q     <= hgt_d;
      bpp_q     <= bpp_d;
      srow_q    <= srow_d;
      bir_q     <= bir_d;
      lastb_q   <= lastb_d;
      job_vld_q <= job_vld_d;
      job_idx_q <= job_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_job) begin
      if (is_last_hdr) begin
        job_kind_q <= hdr_kind;
        job_byte_q <= '0;
        job_base_q <= '0;
        job_row_q  <= '0;
        job_cnt_q  <= 4'd1;
        job_w_q    <= w_ok_val;
        job_h_q    <= h_ok_val;
        job_lrow_q <= 1'b0;
        job_done_q <= (hdr_kind == KIND_ACCEPTED) && empty_img;
      end else begin
        job_kind_q <= KIND_PIXEL;
        job_byte_q <= din;
        job_base_q <= base_col;
        job_row_q  <= 12'(row_full);
        job_cnt_q  <= pix_cnt;
        job_w_q    <= c_wid[WW-1:0];
        job_h_q    <= c_hgt[WH-1:0];
        job_lrow_q <= last_row;
        job_done_q <= 1'b0;
      end
    end
  end

  // Output register
  logic        out_vld_q, out_vld_d;
  kind_e       out_kind_q;
  logic        out_pix_q, out_last_q, out_done_q;
  logic [11:0] out_col_q, out_row_q;
  logic [12:0] out_w_q, out_h_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= job_kind_q;
      out_pix_q  <= j_pix;
      out_col_q  <= (job_kind_q == KIND_PIXEL) ? 12'(j_col) : 12'd0;
      out_row_q  <= job_row_q;
      out_w_q    <= 13'(job_w_q);
      out_h_q    <= 13'(job_h_q);
      out_last_q <= job_last;
      out_done_q <= j_done;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_done_q, out_h_q, out_w_q, out_row_q, out_col_q,
                          out_pix_q};

`ifndef ASSERT_OFF
  // The result index never runs past the number of results the byte owes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_vld_q |-> (4'(job_idx_q) < job_cnt_q))
    else $error("unpack index beyond result count");

  // Status results are always the only result of their byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_PIXEL) |-> m_axis_tlast)
    else $error("status result without last flag");

  // Pixel phase is only entered for an image with nonzero size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> (wid_q != '0 && hgt_q != '0))
    else $error("pixel phase with empty image");

  // A byte is never taken while the unpack stage still owes results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_vld_q && !(out_load && job_last)) |-> !s_axis_tready)
    else $error("input taken while unpack stage busy");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the monochrome BMP pixel unpacker.
// ----------------------------------------------------------------------------
// Whole and broken BMP files are streamed into the block one byte per request.
// A behavioral decoder in this file follows the same byte stream and queues
// the status and pixel results that each accepted byte must produce. Every
// result that leaves the block is compared field by field with the oldest
// queued one. Both sides of the stream idle and stall at random, and the
// output is held off for a long stretch at least once.
module tb_top;
  import bmpu_pkg::*;

  localparam int unsigned MAX_W = 4096;
  localparam int unsigned MAX_H = 4096;
  localparam int          HOLD_CYCLES = 400;

  typedef struct {
    kind_e       kind;
    logic        pix;
    logic [11:0] col;
    logic [11:0] row;
    logic [12:0] w;
    logic [12:0] h;
    logic        last;
    logic        done;
  } decoded_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = 8'h00;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // Decoder state that follows the byte stream.
  logic [31:0] hdr_count;
  logic [7:0]  sig_lead;
  logic [31:0] data_start;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [15:0] bit_depth;
  phase_e      parse_phase;
  logic [31:0] file_row;
  logic [31:0] row_byte;

  decoded_t pending_decodes[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int file_bytes     = 0;
  int headers_sent   = 0;
  int pixels_checked = 0;
  int status_checked = 0;

  bmp_mono_pixel_unpacker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  task automatic clear_decoder();
    hdr_count   = '0;
    sig_lead    = '0;
    data_start  = '0;
    img_w       = '0;
    img_h       = '0;
    bit_depth   = '0;
    parse_phase = PH_HEADER;
    file_row    = '0;
    row_byte    = '0;
  endtask

  initial clear_decoder();

  // Queues every result that one accepted file byte must produce.
  task automatic decode_file_byte(input logic [7:0] b, input logic restart);
    logic [31:0] p;
    logic [31:0] col;
    logic [31:0] out_row;
    logic        w_ok;
    logic        h_ok;
    logic        last_row;
    decoded_t    r;
    int          k;
    if (restart) clear_decoder();
    if (parse_phase == PH_HEADER) begin
      p = hdr_count;
      if (p == 0) sig_lead = b;
      else if (p == 1) begin
        if (b != SIG_M) sig_lead = '0;
      end else if (p >= 10 && p <= 13) data_start |= 32'(b) << (8 * (p - 10));
      else if (p >= 18 && p <= 21) img_w |= 32'(b) << (8 * (p - 18));
      else if (p >= 22 && p <= 25) img_h |= 32'(b) << (8 * (p - 22));
      else if (p >= 28 && p <= 29) bit_depth |= 16'(b) << (8 * (p - 28));
      hdr_count = p + 1;
      if (p == HDR_BYTES - 1) begin
        w_ok   = !img_w[31] && img_w <= MAX_W;
        h_ok   = !img_h[31] && img_h <= MAX_H;
        r.pix  = 1'b0;
        r.col  = '0;
        r.row  = '0;
        r.w    = w_ok ? img_w[12:0] : '0;
        r.h    = h_ok ? img_h[12:0] : '0;
        r.last = 1'b1;
        r.done = 1'b0;
        if (sig_lead != SIG_B) r.kind = KIND_NOT_BMP;
        else if (bit_depth != BPP_MONO) r.kind = KIND_BAD_DEPTH;
        else if (!w_ok || !h_ok || data_start < HDR_BYTES) r.kind = KIND_BAD_SIZE;
        else r.kind = KIND_ACCEPTED;
        if (r.kind != KIND_ACCEPTED) begin
          parse_phase = PH_DONE;
        end else if (img_w == 0 || img_h == 0) begin
          r.done      = 1'b1;
          parse_phase = PH_DONE;
        end else begin
          parse_phase = (data_start > HDR_BYTES) ? PH_SKIP : PH_PIXELS;
        end
        pending_decodes.push_back(r);
      end
    end else if (parse_phase == PH_SKIP && hdr_count < data_start) begin
      hdr_count = hdr_count + 1;
    end else if (parse_phase == PH_SKIP || parse_phase == PH_PIXELS) begin
      parse_phase = PH_PIXELS;
      out_row  = img_h - 1 - file_row;
      last_row = (file_row + 1 == img_h);
      for (k = 0; k < 8; k++) begin
        col = row_byte * 8 + k;
        // Columns past the width belong to the row padding.
        if (col < img_w) begin
          r.kind = KIND_PIXEL;
          r.pix  = b[7 - k];
          r.col  = col[11:0];
          r.row  = out_row[11:0];
          r.w    = img_w[12:0];
          r.h    = img_h[12:0];
          r.last = (k == 7) || (col + 1 == img_w);
          r.done = last_row && (col + 1 == img_w);
          pending_decodes.push_back(r);
        end
      end
      row_byte = row_byte + 1;
      if (row_byte >= ((img_w + 32'd31) / 32'd32) * 32'd4) begin
        row_byte = '0;
        file_row = file_row + 1;
        if (file_row >= img_h) parse_phase = PH_DONE;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 30)
      $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               pixels_checked + status_checked, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Input side first, so a byte is decoded before any result can be matched.
  always @(posedge clk_i) begin : monitor
    decoded_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      decode_file_byte(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(m_axis_tuser), 32'hFFFF_FFFF);
      end else begin
        want = pending_decodes.pop_front();
        check_field("kind", 32'(m_axis_tuser), 32'(want.kind));
        check_field("pixel", 32'(m_axis_tdata[0]), 32'(want.pix));
        check_field("column", 32'(m_axis_tdata[12:1]), 32'(want.col));
        check_field("row", 32'(m_axis_tdata[24:13]), 32'(want.row));
        check_field("width", 32'(m_axis_tdata[37:25]), 32'(want.w));
        check_field("height", 32'(m_axis_tdata[50:38]), 32'(want.h));
        check_field("image done", 32'(m_axis_tdata[51]), 32'(want.done));
        check_field("unused data bits", 32'(m_axis_tdata[55:52]), 32'd0);
        check_field("last", 32'(m_axis_tlast), 32'(want.last));
        if (want.kind == KIND_PIXEL) pixels_checked++;
        else status_checked++;
      end
    end
  end

  // Output side: random stalls, or a solid hold-off while hold_left runs down.
  // A new hold-off starts whenever a test raises hold_requests.
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served   <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the byte was taken.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_noise(input int count, input int restart_pct);
    int i;
    for (i = 0; i < count; i++)
      send_byte(8'($urandom_range(255)), $urandom_range(99) < restart_pct);
  endtask

  // Sends the first nbytes of a header; bytes outside the parsed fields are random.
  task automatic send_header(input logic [7:0] s0, input logic [7:0] s1,
                             input logic [31:0] ofs, input logic [31:0] wid,
                             input logic [31:0] hgt, input logic [15:0] bpp,
                             input int nbytes);
    int         i;
    logic [7:0] b;
    headers_sent++;
    for (i = 0; i < nbytes; i++) begin
      b = 8'($urandom_range(255));
      if (i == 0) b = s0;
      else if (i == 1) b = s1;
      else if (i >= 10 && i <= 13) b = ofs[8 * (i - 10) +: 8];
      else if (i >= 18 && i <= 21) b = wid[8 * (i - 18) +: 8];
      else if (i >= 22 && i <= 25) b = hgt[8 * (i - 22) +: 8];
      else if (i >= 28 && i <= 29) b = bpp[8 * (i - 28) +: 8];
      send_byte(b, i == 0);
      file_bytes++;
    end
  endtask

  // A valid header, the gap up to the pixel data, the given number of
  // stored rows, then bytes that should be ignored.
  task automatic send_image(input int wid, input int hgt, input int ofs,
                            input int rows, input int trailing);
    int i;
    int line;
    send_header(SIG_B, SIG_M, ofs, wid, hgt, BPP_MONO, HDR_BYTES);
    line = ((wid + 31) / 32) * 4;
    for (i = HDR_BYTES; i < ofs + rows * line; i++) begin
      send_byte(8'($urandom_range(255)), 1'b0);
      file_bytes++;
    end
    send_noise(trailing, 0);
  endtask

  // Skip gap, row padding, bottom-up rows and a byte after the image.
  task automatic test_basic_images();
    send_image(13, 2, 56, 2, 1);
  endtask

  task automatic test_header_rejects();
    // A bad signature outranks a bad depth.
    send_header(8'hFF, 8'hFF, 54, 8, 2, 16'd24, HDR_BYTES);
    send_header(SIG_B, SIG_M, 54, 8, 2, 16'h0101, HDR_BYTES);
    // Offset inside the header and a negative height, with the widest width.
    send_header(SIG_B, SIG_M, 53, 4096, 32'hFFFF_FFFF, BPP_MONO, HDR_BYTES);
  endtask

  task automatic test_empty_images();
    send_image(0, 5, 54, 0, 1);
  endtask

  // A header cut short, then an image cut short by the next file.
  task automatic test_restarts();
    send_header(SIG_B, SIG_M, 54, 16, 2, BPP_MONO, 8);
    send_image(9, 2, 54, 1, 0);
  endtask

  task automatic test_back_pressure();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
    send_image(40, 2, 54, 2, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct   = 8;
    sink_stall_pct = 86;
    test_basic_images();
    test_header_rejects();

    src_idle_pct   = 86;
    sink_stall_pct = 8;
    test_empty_images();
    test_restarts();

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_back_pressure();

    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);

    $display("Streamed %0d file bytes in %0d headers; checked %0d pixels, %0d status.",
             file_bytes, headers_sent, pixels_checked, status_checked);
    $display("Run included rejected headers, an empty image, restarts mid-file "
             , "and a long output stall.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
